@@ src/rqi_pkg.sv @@
package rqi_pkg;

   // field and register widths
   localparam int unsigned CW   = 32;
   localparam int unsigned RW   = 31;
   localparam int unsigned IDXW = 3;

   // segment length multiplier
   localparam int unsigned SEG_SCALE = 200;

   // exact dot product widths
   localparam int unsigned WPROD_W = 65;
   localparam int unsigned DPROD_W = 64;
   localparam int unsigned WP_W    = 67;
   localparam int unsigned DN_W    = 66;
   localparam int unsigned VP_W    = 74;

   // point arithmetic widths
   localparam int unsigned OFF_W = 40;
   localparam int unsigned PT_W  = 41;

   // register indexes
   localparam logic [IDXW-1:0] REG_NORMAL_X   = 3'd0;
   localparam logic [IDXW-1:0] REG_NORMAL_Y   = 3'd1;
   localparam logic [IDXW-1:0] REG_NORMAL_Z   = 3'd2;
   localparam logic [IDXW-1:0] REG_CENTER_X   = 3'd3;
   localparam logic [IDXW-1:0] REG_CENTER_Y   = 3'd4;
   localparam logic [IDXW-1:0] REG_CENTER_Z   = 3'd5;
   localparam logic [IDXW-1:0] REG_RECT_WIDTH = 3'd6;
   localparam logic [IDXW-1:0] REG_RECT_HGT   = 3'd7;

   // ray data that rides along the pipeline
   typedef struct packed {
      logic [2:0][CW-1:0] org;
      logic [2:0][CW-1:0] dir;
      logic               miss;
      logic               eq;
   } side_type;

endpackage

@@ src/rqi_req_if.sv @@
interface rqi_req_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       origin_x;
   logic signed [31:0]       origin_y;
   logic signed [31:0]       origin_z;
   logic signed [31:0]       dir_x;
   logic signed [31:0]       dir_y;
   logic signed [31:0]       dir_z;

   modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
   modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

@@ src/rqi_rsp_if.sv @@
interface rqi_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] hit_x;
   logic signed [31:0] hit_y;
   logic signed [31:0] hit_z;

   modport source(output valid, hit, hit_x, hit_y, hit_z, input ready);
   modport sink(input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface

@@ src/rqi_csr_if.sv @@
interface rqi_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ src/rqi_dot.sv @@
module rqi_dot (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [2:0][rqi_pkg::CW-1:0]   org,
   input  logic [2:0][rqi_pkg::CW-1:0]   dir,
   input  logic [2:0][rqi_pkg::CW-1:0]   normal,
   input  logic [2:0][rqi_pkg::CW-1:0]   center,
   input  logic                          rect_zero,
   output logic                          out_valid,
   output logic [rqi_pkg::VP_W-1:0]      aw,
   output logic [rqi_pkg::VP_W-1:0]      av,
   output rqi_pkg::side_type             side
);

   localparam int unsigned CW = rqi_pkg::CW;
   localparam int unsigned WPW = rqi_pkg::WPROD_W;
   localparam int unsigned DPW = rqi_pkg::DPROD_W;
   localparam int unsigned WP_W = rqi_pkg::WP_W;
   localparam int unsigned DN_W = rqi_pkg::DN_W;
   localparam int unsigned VP_W = rqi_pkg::VP_W;

   // stage A: lane products
   logic                  va_ff;
   logic signed [WPW-1:0] wprod_ff [3];
   logic signed [WPW-1:0] wprod_in [3];
   logic signed [DPW-1:0] dprod_ff [3];
   logic signed [DPW-1:0] dprod_in [3];
   rqi_pkg::side_type     sa_ff;

   always_comb begin
      logic signed [CW:0] cmo;
      for (int i = 0; i < 3; i++) begin
         cmo = $signed({center[i][CW-1], center[i]}) - $signed({org[i][CW-1], org[i]});
         wprod_in[i] = WPW'(cmo) * WPW'($signed(normal[i]));
         dprod_in[i] = DPW'($signed(dir[i])) * DPW'($signed(normal[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            wprod_ff[i] <= wprod_in[i];
            dprod_ff[i] <= dprod_in[i];
         end
         sa_ff.org  <= org;
         sa_ff.dir  <= dir;
         sa_ff.miss <= 1'b0;
         sa_ff.eq   <= 1'b0;
      end
   end

   // stage B: lane sums
   logic                   vb_ff;
   logic signed [WP_W-1:0] wp_ff;
   logic signed [WP_W-1:0] wp_in;
   logic signed [DN_W-1:0] dn_ff;
   logic signed [DN_W-1:0] dn_in;
   rqi_pkg::side_type      sb_ff;

   always_comb begin
      wp_in = WP_W'(wprod_ff[0]) + WP_W'(wprod_ff[1]) + WP_W'(wprod_ff[2]);
      dn_in = DN_W'(dprod_ff[0]) + DN_W'(dprod_ff[1]) + DN_W'(dprod_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wp_ff <= wp_in;
         dn_ff <= dn_in;
         sb_ff <= sa_ff;
      end
   end

   // stage C: scale by segment length, magnitudes and early miss
   logic                   vc_ff;
   logic [VP_W-1:0]        aw_ff;
   logic [VP_W-1:0]        aw_in;
   logic [VP_W-1:0]        av_ff;
   logic [VP_W-1:0]        av_in;
   rqi_pkg::side_type      sc_ff;
   rqi_pkg::side_type      sc_in;

   always_comb begin
      logic signed [VP_W-1:0] wp_ext;
      logic signed [VP_W-1:0] vp;
      logic                   wn;
      logic                   vn;
      wp_ext = VP_W'(wp_ff);
      vp     = VP_W'(dn_ff) * VP_W'(rqi_pkg::SEG_SCALE);
      wn     = wp_ff[WP_W-1];
      vn     = vp[VP_W-1];
      aw_in  = wn ? VP_W'(-wp_ext) : VP_W'(wp_ext);
      av_in  = vn ? VP_W'(-vp) : VP_W'(vp);
      sc_in  = sb_ff;
      sc_in.miss = (av_in == '0) || rect_zero || ((aw_in != '0) && (wn != vn))
                   || (av_in < aw_in);
      sc_in.eq   = (av_in == aw_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aw_ff <= aw_in;
         av_ff <= av_in;
         sc_ff <= sc_in;
      end
   end

   assign out_valid = vc_ff;
   assign aw        = aw_ff;
   assign av        = av_ff;
   assign side      = sc_ff;

endmodule

@@ src/rqi_div.sv @@
module rqi_div #(
   parameter int unsigned KBITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [rqi_pkg::VP_W-1:0]   aw,
   input  logic [rqi_pkg::VP_W-1:0]   av,
   input  rqi_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [KBITS-1:0]           quot,
   output rqi_pkg::side_type          out_side
);

   localparam int unsigned VP_W = rqi_pkg::VP_W;
   localparam int unsigned DS   = KBITS / 2;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [VP_W:0] div_step(input logic [VP_W-1:0] r,
                                              input logic [VP_W-1:0] d);
      logic [VP_W:0] t;
      logic [VP_W:0] diff;
      t    = {r, 1'b0};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         return {1'b1, diff[VP_W-1:0]};
      end else begin
         return {1'b0, t[VP_W-1:0]};
      end
   endfunction

   logic                 v_ff    [DS];
   logic [VP_W-1:0]      r_ff    [DS];
   logic [VP_W-1:0]      d_ff    [DS];
   logic [KBITS-1:0]     q_ff    [DS];
   rqi_pkg::side_type    side_ff [DS];

   // two quotient bits per stage
   for (genvar s = 0; s < DS; s++) begin : g_stage
      logic              v_src;
      logic [VP_W-1:0]   r_src;
      logic [VP_W-1:0]   d_src;
      logic [KBITS-1:0]  q_src;
      rqi_pkg::side_type side_src;
      logic [VP_W:0]     st1;
      logic [VP_W:0]     st2;

      if (s == 0) begin : g_first
         always_comb begin
            v_src    = in_valid;
            r_src    = aw;
            d_src    = av;
            q_src    = '0;
            side_src = in_side;
         end
      end else begin : g_next
         always_comb begin
            v_src    = v_ff[s-1];
            r_src    = r_ff[s-1];
            d_src    = d_ff[s-1];
            q_src    = q_ff[s-1];
            side_src = side_ff[s-1];
         end
      end

      always_comb begin
         st1 = div_step(r_src, d_src);
         st2 = div_step(st1[VP_W-1:0], d_src);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]    <= st2[VP_W-1:0];
            d_ff[s]    <= d_src;
            q_ff[s]    <= {q_src[KBITS-3:0], st1[VP_W], st2[VP_W]};
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[DS-1];
   assign quot      = q_ff[DS-1];
   assign out_side  = side_ff[DS-1];

endmodule

@@ src/rqi_point.sv @@
module rqi_point #(
   parameter int unsigned KBITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [KBITS-1:0]              quot,
   input  rqi_pkg::side_type             in_side,
   input  logic [2:0][rqi_pkg::CW-1:0]   center,
   input  logic [rqi_pkg::RW-1:0]        rect_width,
   input  logic [rqi_pkg::RW-1:0]        rect_height,
   output logic                          out_valid,
   output logic                          hit,
   output logic [2:0][rqi_pkg::CW-1:0]   hit_pt
);

   localparam int unsigned CW    = rqi_pkg::CW;
   localparam int unsigned RW    = rqi_pkg::RW;
   localparam int unsigned OFF_W = rqi_pkg::OFF_W;
   localparam int unsigned PT_W  = rqi_pkg::PT_W;
   localparam int unsigned QW    = KBITS + 1;
   localparam int unsigned QLO   = QW / 2;
   localparam int unsigned QHI   = QW - QLO;
   localparam int unsigned MW    = CW + QW;
   localparam int unsigned SW    = MW + 8;
   localparam int unsigned DW    = PT_W + 1;

   // M1: |dir| times the two halves of k
   logic                   v1_ff;
   logic [CW+QLO-1:0]      pl_ff [3];
   logic [CW+QHI-1:0]      ph_ff [3];
   rqi_pkg::side_type      s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      logic [QW-1:0] q;
      logic [CW-1:0] ad;
      if (en) begin
         q = in_side.eq ? (QW'(1) << KBITS) : {1'b0, quot};
         for (int i = 0; i < 3; i++) begin
            ad = in_side.dir[i][CW-1] ? (~in_side.dir[i] + CW'(1)) : in_side.dir[i];
            pl_ff[i] <= (CW+QLO)'(ad) * (CW+QLO)'(q[QLO-1:0]);
            ph_ff[i] <= (CW+QHI)'(ad) * (CW+QHI)'(q[QW-1:QLO]);
         end
         s1_ff <= in_side;
      end
   end

   // M2: join partial products
   logic               v2_ff;
   logic [MW-1:0]      m_ff [3];
   rqi_pkg::side_type  s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            m_ff[i] <= MW'(pl_ff[i]) + (MW'(ph_ff[i]) << QLO);
         end
         s2_ff <= s1_ff;
      end
   end

   // M3: times segment scale, plus rounding half
   logic               v3_ff;
   logic [SW-1:0]      ms_ff [3];
   rqi_pkg::side_type  s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ms_ff[i] <= SW'(m_ff[i]) * SW'(rqi_pkg::SEG_SCALE) + (SW'(1) << (KBITS - 1));
         end
         s3_ff <= s2_ff;
      end
   end

   // M4: rounded offset applied to the origin
   logic                   v4_ff;
   logic signed [PT_W-1:0] p_ff [3];
   rqi_pkg::side_type      s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [PT_W-1:0] o_ext;
      logic signed [PT_W-1:0] off_ext;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            o_ext   = PT_W'($signed(s3_ff.org[i]));
            off_ext = $signed({1'b0, ms_ff[i][KBITS+OFF_W-1:KBITS]});
            p_ff[i] <= s3_ff.dir[i][CW-1] ? (o_ext - off_ext) : (o_ext + off_ext);
         end
         s4_ff <= s3_ff;
      end
   end

   // M5: bounds test and saturation
   logic               v5_ff;
   logic               hit_ff;
   logic [2:0][CW-1:0] pt_ff;
   logic               hit_in;
   logic [2:0][CW-1:0] pt_in;

   always_comb begin
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic [DW-1:0]        ax;
      logic [DW-1:0]        ay;
      logic                 out_x;
      logic                 out_y;
      dx    = DW'(p_ff[0]) - DW'($signed(center[0]));
      dy    = DW'(p_ff[1]) - DW'($signed(center[1]));
      ax    = dx[DW-1] ? DW'(-dx) : DW'(dx);
      ay    = dy[DW-1] ? DW'(-dy) : DW'(dy);
      out_x = {ax, 1'b0} > (DW+1)'(rect_width);
      out_y = {ay, 1'b0} > (DW+1)'(rect_height);
      hit_in = !s4_ff.miss && !out_x && !out_y;
      for (int i = 0; i < 3; i++) begin
         if (!hit_in) begin
            pt_in[i] = '0;
         end else if (!p_ff[i][PT_W-1] && (p_ff[i][PT_W-2:CW-1] != '0)) begin
            pt_in[i] = {1'b0, {(CW-1){1'b1}}};
         end else if (p_ff[i][PT_W-1] && (p_ff[i][PT_W-2:CW-1] != '1)) begin
            pt_in[i] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            pt_in[i] = p_ff[i][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         pt_ff  <= pt_in;
      end
   end

   assign out_valid = v5_ff;
   assign hit       = hit_ff;
   assign hit_pt    = pt_ff;

endmodule

@@ src/ray_quad_intersect_top.sv @@
// Ray against rectangle intersection test, fully pipelined.
// req_bus: one ray per beat (origin and direction, Q16.16). The segment
// tested is origin + 200 * direction.
// rsp_bus: one result per ray, in order: hit flag and hit point, with the
// point zero on a miss and saturated to 32 bits on a hit.
// csr_bus: register writes (normal, center, width, height), always ready.
// Write registers only while no ray is in flight.
// A ray passes three dot product stages, FRAC_BITS divider stages at
// two quotient bits each, and five hit point stages.
// It takes one ray per cycle while the pipeline advances. The whole
// pipeline advances together; while a response waits for
// rsp_bus.ready and the output stage holds data, every stage holds and
// req_bus.ready is low.
// Reset clears all stage valid bits and loads the plane (0,0,1), center
// at the origin and a 2 x 2 rectangle.
module ray_quad_intersect_top #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   rqi_req_if.sink   req_bus,
   rqi_rsp_if.source rsp_bus,
   rqi_csr_if.sink   csr_bus
);

   localparam int unsigned CW    = rqi_pkg::CW;
   localparam int unsigned RW    = rqi_pkg::RW;
   localparam int unsigned KBITS = 2 * FRAC_BITS;

   // configuration registers
   logic [2:0][CW-1:0] normal_ff;
   logic [2:0][CW-1:0] center_ff;
   logic [RW-1:0]      width_ff;
   logic [RW-1:0]      height_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= CW'(1) << FRAC_BITS;
         center_ff <= '0;
         width_ff  <= RW'(2) << FRAC_BITS;
         height_ff <= RW'(2) << FRAC_BITS;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            rqi_pkg::REG_NORMAL_X:   normal_ff[0] <= csr_bus.data;
            rqi_pkg::REG_NORMAL_Y:   normal_ff[1] <= csr_bus.data;
            rqi_pkg::REG_NORMAL_Z:   normal_ff[2] <= csr_bus.data;
            rqi_pkg::REG_CENTER_X:   center_ff[0] <= csr_bus.data;
            rqi_pkg::REG_CENTER_Y:   center_ff[1] <= csr_bus.data;
            rqi_pkg::REG_CENTER_Z:   center_ff[2] <= csr_bus.data;
            rqi_pkg::REG_RECT_WIDTH: width_ff     <= csr_bus.data[RW-1:0];
            rqi_pkg::REG_RECT_HGT:   height_ff    <= csr_bus.data[RW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance
   logic en;
   logic pt_valid;

   assign en            = !pt_valid || rsp_bus.ready;
   assign req_bus.ready = en;

   logic [2:0][CW-1:0] org;
   logic [2:0][CW-1:0] dir;

   assign org = {req_bus.origin_z, req_bus.origin_y, req_bus.origin_x};
   assign dir = {req_bus.dir_z, req_bus.dir_y, req_bus.dir_x};

   // dot products
   logic                      dot_valid;
   logic [rqi_pkg::VP_W-1:0]  aw;
   logic [rqi_pkg::VP_W-1:0]  av;
   rqi_pkg::side_type         dot_side;

   rqi_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .org       (org),
      .dir       (dir),
      .normal    (normal_ff),
      .center    (center_ff),
      .rect_zero ((width_ff == '0) || (height_ff == '0)),
      .out_valid (dot_valid),
      .aw        (aw),
      .av        (av),
      .side      (dot_side)
   );

   // segment parameter
   logic              div_valid;
   logic [KBITS-1:0]  quot;
   rqi_pkg::side_type div_side;

   rqi_div #(.KBITS(KBITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dot_valid),
      .aw        (aw),
      .av        (av),
      .in_side   (dot_side),
      .out_valid (div_valid),
      .quot      (quot),
      .out_side  (div_side)
   );

   // hit point and bounds
   logic               hit;
   logic [2:0][CW-1:0] hit_pt;

   rqi_point #(.KBITS(KBITS)) u_point (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (div_valid),
      .quot        (quot),
      .in_side     (div_side),
      .center      (center_ff),
      .rect_width  (width_ff),
      .rect_height (height_ff),
      .out_valid   (pt_valid),
      .hit         (hit),
      .hit_pt      (hit_pt)
   );

   assign rsp_bus.valid = pt_valid;
   assign rsp_bus.hit   = hit;
   assign rsp_bus.hit_x = hit_pt[0];
   assign rsp_bus.hit_y = hit_pt[1];
   assign rsp_bus.hit_z = hit_pt[2];

endmodule
